// File: sv/capacity_match_acceptor_assert.svh
`ifndef CAPACITY_MATCH_ACCEPTOR_ASSERT_SVH
`define CAPACITY_MATCH_ACCEPTOR_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset
`define CMA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("capacity_match_acceptor: same-cycle check failed");

// Next-cycle implication, sampled on clk, off during reset
`define CMA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("capacity_match_acceptor: next-cycle check failed");

`endif

// File: sv/cma_pkg.sv
package cma_pkg;

  // Sizes
  localparam int APPLICANT_SLOTS = 256;
  localparam int MAX_SEATS       = 16;
  localparam int ID_W            = 8;
  localparam int RANK_W          = 8;
  localparam int CNT_W           = 5;
  localparam int SEAT_W          = $clog2(MAX_SEATS);
  localparam int SLOT_W          = $clog2(APPLICANT_SLOTS);

  // Commands
  localparam logic [1:0] CMD_LOAD     = 2'd0;
  localparam logic [1:0] CMD_PROPOSE  = 2'd1;
  localparam logic [1:0] CMD_WITHDRAW = 2'd2;
  localparam logic [1:0] CMD_QUERY    = 2'd3;

  // Result status codes
  localparam logic [2:0] ST_LOADED    = 3'd0;
  localparam logic [2:0] ST_FREE      = 3'd1;
  localparam logic [2:0] ST_DISPLACED = 3'd2;
  localparam logic [2:0] ST_REJECTED  = 3'd3;
  localparam logic [2:0] ST_REMOVED   = 3'd4;
  localparam logic [2:0] ST_NOT_HELD  = 3'd5;
  localparam logic [2:0] ST_HELD      = 3'd6;
  localparam logic [2:0] ST_ALREADY   = 3'd7;

  // Register byte addresses
  localparam logic [2:0] ADDR_CAPACITY = 3'd0;

  // Candidate in the worst-seat search tree
  typedef struct packed {
    logic              valid;
    logic [RANK_W-1:0] rank;
    logic [SEAT_W-1:0] idx;
  } worst_t;

endpackage

// File: sv/cma_ram.sv
module cma_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/capacity_match_acceptor.sv
// Channel   Dir  Signals                          Contents
// s_*       in   s_tvalid/s_tready/s_tdata/s_tuser command request
// m_*       out  m_tvalid/m_tready/m_tdata/m_tuser one result per request
// apb       in   psel/penable/pwrite/paddr/...    capacity register at 0x0
//
// Each request has an accept cycle, which issues the rank table read, and an
// execute cycle, which uses the read data and compares over all held seats.
// The rank table read port sets this split; one request is in work at a time.
// Reset (rst, synchronous) clears seats, held count and capacity; the rank
// table is not cleared and needs no clearing pass.
// A full result register stalls the execute cycle until m_tready.
module capacity_match_acceptor (
  input  logic        clk,
  input  logic        rst,
  // request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [7:0] applicant_id, [15:8] rank_position
  input  logic [1:0]  s_tuser,   // [1:0] command
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] displaced_id, [12:8] held_count, rest 0
  output logic [2:0]  m_tuser,   // [2:0] status
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state;
  logic [cma_pkg::CNT_W-1:0] capacity;

  // request registers
  logic [1:0]                 req_cmd;
  logic [cma_pkg::ID_W-1:0]   req_id;
  logic [cma_pkg::RANK_W-1:0] req_pos;

  // seat store
  logic [cma_pkg::ID_W-1:0]   seat_app  [cma_pkg::MAX_SEATS];
  logic [cma_pkg::RANK_W-1:0] seat_rank [cma_pkg::MAX_SEATS];
  logic [cma_pkg::MAX_SEATS-1:0] seat_valid;
  logic [cma_pkg::CNT_W-1:0]  held;

  logic                       accept;
  logic                       exec_fire;
  logic [cma_pkg::RANK_W-1:0] rank_rdata;

  // ---- configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= '0;
    end else if (psel && penable && pwrite && (paddr[2] == cma_pkg::ADDR_CAPACITY[2])) begin
      capacity <= pwdata[cma_pkg::CNT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == cma_pkg::ADDR_CAPACITY[2]) begin
      prdata[cma_pkg::CNT_W-1:0] = capacity;
    end
  end

  // ---- control
  assign s_tready  = (state == S_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign exec_fire = (state == S_EXEC) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: if (accept) state <= S_EXEC;
        S_EXEC: if (exec_fire) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_cmd <= s_tuser;
      req_id  <= s_tdata[7:0];
      req_pos <= s_tdata[15:8];
    end
  end

  // ---- rank table: read on accept, load writes in execute
  cma_ram #(
    .WIDTH(cma_pkg::RANK_W),
    .DEPTH(cma_pkg::APPLICANT_SLOTS)
  ) u_rank (
    .clk  (clk),
    .we   (exec_fire && (req_cmd == cma_pkg::CMD_LOAD)),
    .waddr(req_id[cma_pkg::SLOT_W-1:0]),
    .wdata(req_pos),
    .re   (accept),
    .raddr(s_tdata[cma_pkg::SLOT_W-1:0]),
    .rdata(rank_rdata)
  );

  // ---- seat lookups
  logic                       match_hit;
  logic [cma_pkg::SEAT_W-1:0] match_idx;
  logic                       free_hit;
  logic [cma_pkg::SEAT_W-1:0] free_idx;

  // lowest matching seat and lowest free seat
  always_comb begin
    match_hit = 1'b0;
    match_idx = '0;
    free_hit  = 1'b0;
    free_idx  = '0;
    for (int s = cma_pkg::MAX_SEATS - 1; s >= 0; s--) begin
      if (seat_valid[s] && (seat_app[s] == req_id)) begin
        match_hit = 1'b1;
        match_idx = cma_pkg::SEAT_W'(s);
      end
      if (!seat_valid[s]) begin
        free_hit = 1'b1;
        free_idx = cma_pkg::SEAT_W'(s);
      end
    end
    if (req_id == '0) begin
      match_hit = 1'b0;
    end
  end

  // worst held rank: pairwise tree, left side wins ties (lower seat)
  function automatic cma_pkg::worst_t pick(cma_pkg::worst_t a, cma_pkg::worst_t b);
    if (b.valid && (!a.valid || (b.rank > a.rank))) begin
      return b;
    end
    return a;
  endfunction

  cma_pkg::worst_t tree [2*cma_pkg::MAX_SEATS];

  always_comb begin
    for (int s = 0; s < 2*cma_pkg::MAX_SEATS; s++) begin
      tree[s] = '0;
    end
    for (int s = 0; s < cma_pkg::MAX_SEATS; s++) begin
      tree[cma_pkg::MAX_SEATS + s].valid = seat_valid[s];
      tree[cma_pkg::MAX_SEATS + s].rank  = seat_rank[s];
      tree[cma_pkg::MAX_SEATS + s].idx   = cma_pkg::SEAT_W'(s);
    end
    for (int n = cma_pkg::MAX_SEATS - 1; n >= 1; n--) begin
      tree[n] = pick(tree[2*n], tree[2*n+1]);
    end
  end

  // ---- execute decision
  logic [cma_pkg::CNT_W-1:0]  eff_cap;
  logic [2:0]                 status;
  logic [cma_pkg::ID_W-1:0]   displaced;
  logic                       seat_we;
  logic                       seat_clr;
  logic [cma_pkg::SEAT_W-1:0] seat_idx;
  logic [cma_pkg::CNT_W-1:0]  held_next;
  cma_pkg::worst_t            worst;

  assign eff_cap = (capacity > cma_pkg::CNT_W'(cma_pkg::MAX_SEATS))
                 ? cma_pkg::CNT_W'(cma_pkg::MAX_SEATS) : capacity;
  assign worst   = tree[1];

  always_comb begin
    status    = cma_pkg::ST_REJECTED;
    displaced = '0;
    seat_we   = 1'b0;
    seat_clr  = 1'b0;
    seat_idx  = '0;
    held_next = held;
    unique case (req_cmd)
      cma_pkg::CMD_LOAD: begin
        status = cma_pkg::ST_LOADED;
      end
      cma_pkg::CMD_PROPOSE: begin
        priority if (req_id == '0) begin
          status = cma_pkg::ST_REJECTED;
        end else if (match_hit) begin
          status = cma_pkg::ST_ALREADY;
        end else if (held < eff_cap) begin
          if (free_hit) begin
            status    = cma_pkg::ST_FREE;
            seat_we   = 1'b1;
            seat_idx  = free_idx;
            held_next = held + 1'b1;
          end
        end else if (worst.valid && (rank_rdata < worst.rank)) begin
          status    = cma_pkg::ST_DISPLACED;
          displaced = seat_app[worst.idx];
          seat_we   = 1'b1;
          seat_idx  = worst.idx;
        end else begin
          // full and not strictly better than the worst held rank
          status = cma_pkg::ST_REJECTED;
        end
      end
      cma_pkg::CMD_WITHDRAW: begin
        if (match_hit) begin
          status    = cma_pkg::ST_REMOVED;
          seat_clr  = 1'b1;
          seat_idx  = match_idx;
          held_next = held - 1'b1;
        end else begin
          status = cma_pkg::ST_NOT_HELD;
        end
      end
      cma_pkg::CMD_QUERY: begin
        status = match_hit ? cma_pkg::ST_HELD : cma_pkg::ST_NOT_HELD;
      end
      default: status = cma_pkg::ST_REJECTED;
    endcase
  end

  // ---- seat write-back
  always_ff @(posedge clk) begin
    if (rst) begin
      seat_valid <= '0;
      held       <= '0;
    end else if (exec_fire) begin
      held <= held_next;
      if (seat_we) seat_valid[seat_idx] <= 1'b1;
      if (seat_clr) seat_valid[seat_idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire && seat_we) begin
      seat_app[seat_idx]  <= req_id;
      seat_rank[seat_idx] <= rank_rdata;
    end
  end

  // ---- result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (exec_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      m_tuser <= status;
      m_tdata <= {3'b000, held_next, displaced};
    end
  end

endmodule

// File: sv/capacity_match_acceptor_check.sv
`include "capacity_match_acceptor_assert.svh"

module capacity_match_acceptor_check (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic [2:0]  m_tuser
);

  // held count never exceeds the seat count
  `CMA_ASSERT_NOW(a_count_max, m_tvalid, m_tdata[12:8] <= 5'(cma_pkg::MAX_SEATS))

  // a displaced id shows only with a displacing accept
  `CMA_ASSERT_NOW(a_disp_zero, m_tvalid && (m_tuser != cma_pkg::ST_DISPLACED), m_tdata[7:0] == 8'd0)

  // one request in work: no accept right after an accept
  `CMA_ASSERT_NEXT(a_one_busy, s_tvalid && s_tready, !s_tready)

  // stalled result holds
  `CMA_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

endmodule

bind capacity_match_acceptor capacity_match_acceptor_check u_check (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tuser (m_tuser)
);

// File: bench/tb.sv
module tb;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 185;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;   // [7:0] applicant_id, [15:8] rank_position
  logic [1:0]  s_tuser;   // [1:0] command
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;   // [7:0] displaced_id, [12:8] held_count
  logic [2:0]  m_tuser;   // [2:0] status
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // one expected result per request
  typedef struct packed {
    logic [2:0] status;
    logic [7:0] displaced;
    logic [4:0] held;
  } outcome_t;

  // Tracks the held seats and rank table, predicts each result, checks arrivals
  class match_scoreboard;
    logic [4:0]  capacity;
    logic [7:0]  rank_of [cma_pkg::APPLICANT_SLOTS];
    logic [7:0]  seat_id [cma_pkg::MAX_SEATS];
    logic [7:0]  seat_rank [cma_pkg::MAX_SEATS];
    bit          seat_on [cma_pkg::MAX_SEATS];
    int unsigned held;
    outcome_t    pending [$];
    int          fail_count;
    int unsigned requests;
    int unsigned status_seen [8];

    function new();
      capacity   = '0;
      held       = 0;
      fail_count = 0;
      requests   = 0;
      foreach (rank_of[i]) rank_of[i] = '0;
      foreach (seat_on[s]) begin
        seat_on[s]   = 1'b0;
        seat_id[s]   = '0;
        seat_rank[s] = '0;
      end
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function void set_register(logic [2:0] addr, logic [31:0] value);
      if (addr == cma_pkg::ADDR_CAPACITY) capacity = value[4:0];
    endfunction

    function int find_seat(logic [7:0] id);
      if (id == 0) return -1;
      for (int s = 0; s < cma_pkg::MAX_SEATS; s++)
        if (seat_on[s] && seat_id[s] == id) return s;
      return -1;
    endfunction

    // random currently held id, 0 when nobody is held
    function logic [7:0] held_id();
      logic [7:0] ids [$];
      foreach (seat_on[s]) if (seat_on[s]) ids.insert(ids.size(), seat_id[s]);
      if (ids.size() == 0) return 8'd0;
      return ids[$urandom_range(0, ids.size() - 1)];
    endfunction

    function outcome_t propose(logic [7:0] id);
      outcome_t    o;
      int          worst;
      int unsigned limit;
      logic [7:0]  r;
      o        = '0;
      o.status = cma_pkg::ST_REJECTED;
      worst    = -1;
      limit    = (capacity > cma_pkg::MAX_SEATS) ? cma_pkg::MAX_SEATS : capacity;
      if (id == 0) return o;
      if (find_seat(id) >= 0) begin
        o.status = cma_pkg::ST_ALREADY;
        return o;
      end
      r = rank_of[id];
      // room left: lowest free seat
      if (held < limit) begin
        for (int s = 0; s < cma_pkg::MAX_SEATS; s++) begin
          if (!seat_on[s]) begin
            seat_on[s]   = 1'b1;
            seat_id[s]   = id;
            seat_rank[s] = r;
            held++;
            o.status = cma_pkg::ST_FREE;
            return o;
          end
        end
        return o;
      end
      // full: strictly worse rank wins the search, so ties keep the lowest seat
      for (int s = 0; s < cma_pkg::MAX_SEATS; s++)
        if (seat_on[s] && (worst < 0 || seat_rank[s] > seat_rank[worst])) worst = s;
      if (worst < 0 || r >= seat_rank[worst]) return o;
      o.displaced      = seat_id[worst];
      seat_id[worst]   = id;
      seat_rank[worst] = r;
      o.status         = cma_pkg::ST_DISPLACED;
      return o;
    endfunction

    function void note_request(logic [1:0] cmd, logic [7:0] id, logic [7:0] pos);
      outcome_t o;
      int       s;
      o = '0;
      requests++;
      case (cmd)
        cma_pkg::CMD_LOAD: begin
          rank_of[id] = pos;
          o.status    = cma_pkg::ST_LOADED;
        end
        cma_pkg::CMD_PROPOSE: begin
          o = propose(id);
        end
        cma_pkg::CMD_WITHDRAW: begin
          s = find_seat(id);
          if (s >= 0) begin
            seat_on[s]   = 1'b0;
            seat_id[s]   = '0;
            seat_rank[s] = '0;
            held--;
            o.status = cma_pkg::ST_REMOVED;
          end else begin
            o.status = cma_pkg::ST_NOT_HELD;
          end
        end
        default: begin
          o.status = (find_seat(id) >= 0) ? cma_pkg::ST_HELD : cma_pkg::ST_NOT_HELD;
        end
      endcase
      o.held = 5'(held);
      pending.insert(pending.size(), o);
    endfunction

    function void check_result(logic [2:0] status, logic [7:0] displaced, logic [4:0] count);
      outcome_t want;
      if (pending.size() == 0) begin
        $error("result with no request waiting: status %0d", status);
        fail_count++;
        return;
      end
      want = pending.pop_front();
      status_seen[want.status]++;
      if (status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, status);
        fail_count++;
      end
      if (displaced !== want.displaced) begin
        $error("displaced_id: expected %0d, got %0d", want.displaced, displaced);
        fail_count++;
      end
      if (count !== want.held) begin
        $error("held_count: expected %0d, got %0d", want.held, count);
        fail_count++;
      end
    endfunction
  endclass

  match_scoreboard sb;
  bit              rank_loaded [cma_pkg::APPLICANT_SLOTS];
  bit              idle_on;
  bit              stall_on;
  int              ready_hold;
  int unsigned     cycles;
  int              id_hi;
  int              rank_hi;
  int              cap_plan [PHASES]  = '{16, 31, 1, 5, 0, 3, 20, 16, 2, 8};
  int              id_plan [4]        = '{12, 40, 255, 24};
  int              rank_plan [3]      = '{3, 255, 15};

  capacity_match_acceptor u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #2 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // mostly short waits, now and then a long one
  function automatic int pick_pause(bit enabled);
    int r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 24);
  endfunction

  function automatic logic [7:0] pick_rank();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'd0;
    if (r == 1) return 8'(rank_hi);
    return 8'($urandom_range(0, rank_hi));
  endfunction

  // result side back-pressure
  always @(negedge clk) begin
    if (ready_hold > 0) begin
      ready_hold--;
    end else if (!stall_on) begin
      m_tready <= 1'b1;
    end else begin
      m_tready   <= ($urandom_range(0, 2) != 0);
      ready_hold = pick_pause(1'b1);
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata[7:0], m_tdata[12:8]);
  end

  // present one request and hold it until accepted
  task automatic send_request(logic [1:0] cmd, logic [7:0] id, logic [7:0] pos);
    int gap;
    gap = pick_pause(idle_on);
    if (gap > 0) begin
      @(negedge clk) s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {pos, id};
    do @(posedge clk); while (!s_tready);
    sb.note_request(cmd, id, pos);
    if (cmd == cma_pkg::CMD_LOAD) rank_loaded[id] = 1'b1;
  endtask

  // drop the request line and wait for every outstanding result
  task automatic wait_idle();
    @(negedge clk) s_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  task automatic program_capacity(logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= cma_pkg::ADDR_CAPACITY;
    pwdata  <= value;
    @(negedge clk) penable <= 1'b1;
    @(posedge clk);
    if (pready) sb.set_register(cma_pkg::ADDR_CAPACITY, value);
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk) penable <= 1'b1;
    @(posedge clk);
    if (prdata[4:0] !== sb.capacity) begin
      $error("capacity: expected %0d, got %0d", sb.capacity, prdata[4:0]);
      sb.fail_count++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // hand-picked sequence over the corner cases, capacity 0 then 2
  task automatic directed_requests();
    // zero capacity
    send_request(cma_pkg::CMD_LOAD, 8'd1, 8'd10);
    send_request(cma_pkg::CMD_PROPOSE, 8'd1, 8'd0);
    send_request(cma_pkg::CMD_QUERY, 8'd1, 8'd0);
    send_request(cma_pkg::CMD_WITHDRAW, 8'd1, 8'd0);
    wait_idle();
    program_capacity(32'd2);
    // rank extremes and id zero
    send_request(cma_pkg::CMD_LOAD, 8'd0, 8'd255);
    send_request(cma_pkg::CMD_LOAD, 8'd255, 8'd0);
    send_request(cma_pkg::CMD_LOAD, 8'd2, 8'd20);
    send_request(cma_pkg::CMD_LOAD, 8'd3, 8'd20);
    send_request(cma_pkg::CMD_LOAD, 8'd4, 8'd5);
    send_request(cma_pkg::CMD_PROPOSE, 8'd0, 8'hff);
    send_request(cma_pkg::CMD_WITHDRAW, 8'd0, 8'd0);
    send_request(cma_pkg::CMD_QUERY, 8'd0, 8'd0);
    // fill, already held while full, equal rank, displacement
    send_request(cma_pkg::CMD_PROPOSE, 8'd1, 8'd0);
    send_request(cma_pkg::CMD_PROPOSE, 8'd2, 8'd0);
    send_request(cma_pkg::CMD_PROPOSE, 8'd2, 8'd0);
    send_request(cma_pkg::CMD_PROPOSE, 8'd3, 8'd0);
    send_request(cma_pkg::CMD_PROPOSE, 8'd4, 8'd0);
    send_request(cma_pkg::CMD_PROPOSE, 8'd255, 8'd0);
    // reload does not touch the held rank
    send_request(cma_pkg::CMD_LOAD, 8'd4, 8'd200);
    send_request(cma_pkg::CMD_PROPOSE, 8'd3, 8'd0);
    // free seat reuse, then a tie for worst
    send_request(cma_pkg::CMD_WITHDRAW, 8'd255, 8'd0);
    send_request(cma_pkg::CMD_PROPOSE, 8'd3, 8'd0);
    send_request(cma_pkg::CMD_WITHDRAW, 8'd4, 8'd0);
    send_request(cma_pkg::CMD_PROPOSE, 8'd2, 8'd0);
    send_request(cma_pkg::CMD_PROPOSE, 8'd1, 8'd0);
    send_request(cma_pkg::CMD_QUERY, 8'd1, 8'd0);
  endtask

  task automatic random_request();
    int         pick;
    logic [7:0] id;
    logic [7:0] hid;
    logic [7:0] pos;
    logic [1:0] cmd;
    pick = $urandom_range(0, 99);
    id   = ($urandom_range(0, 19) == 0) ? 8'd0 : 8'($urandom_range(1, id_hi));
    pos  = 8'($urandom_range(0, 255));
    hid  = sb.held_id();
    if (pick < 20) begin
      cmd = cma_pkg::CMD_LOAD;
      pos = pick_rank();
    end else if (pick < 65) begin
      cmd = cma_pkg::CMD_PROPOSE;
      if (hid != 0 && $urandom_range(0, 99) < 15) id = hid;
      // never propose an id with no rank loaded
      if (id != 0 && !rank_loaded[id]) send_request(cma_pkg::CMD_LOAD, id, pick_rank());
    end else begin
      cmd = (pick < 85) ? cma_pkg::CMD_WITHDRAW : cma_pkg::CMD_QUERY;
      if (hid != 0 && $urandom_range(0, 99) < 60) id = hid;
    end
    send_request(cmd, id, pos);
  endtask

  initial begin
    int waited;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = '0;
    m_tready = 1'b0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    idle_on  = 1'b1;
    stall_on = 1'b1;
    ready_hold = 0;
    cycles   = 0;
    id_hi    = 12;
    rank_hi  = 255;
    foreach (rank_loaded[i]) rank_loaded[i] = 1'b0;
    sb = new();
    repeat (5) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    directed_requests();

    // random phases, each under its own capacity and id / rank spread
    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      program_capacity(32'(cap_plan[p]));
      id_hi   = id_plan[p % 4];
      rank_hi = rank_plan[p % 3];
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 50 == 0) begin
          idle_on  = ($urandom_range(0, 3) != 0);
          stall_on = ($urandom_range(0, 3) != 0);
        end
        random_request();
      end
    end

    // drain
    @(negedge clk) s_tvalid <= 1'b0;
    waited = 0;
    while (sb.pending.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    if (sb.pending.size() != 0) begin
      $error("%0d results never arrived", sb.pending.size());
      sb.fail_count++;
    end
    repeat (10) @(posedge clk);

    $display("Ran %0d requests over %0d capacity settings in %0d cycles.",
             sb.requests, PHASES + 2, cycles);
    $display("Status mix, loaded through already held: %0d %0d %0d %0d %0d %0d %0d %0d",
             sb.status_seen[0], sb.status_seen[1], sb.status_seen[2], sb.status_seen[3],
             sb.status_seen[4], sb.status_seen[5], sb.status_seen[6], sb.status_seen[7]);
    if (sb.fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
